### hw/rtl/psd_pkg.sv
// Package for the ping-pong stereo delay: widths, reset values and register indexes.
// No dependencies.
package psd_pkg;
  localparam int unsigned LineDepthDefault  = 65536;
  localparam int unsigned SampleBitsDefault = 24;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [CfgIdxBits-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_DELAY      = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_FEEDBACK   = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_DAMP       = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_TIME_SMOOTH = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_GAIN_SMOOTH = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_SEED_GAIN  = 3'd6;

  localparam logic [23:0] DELAY_TARGET_RESET    = 24'd6144000;
  localparam logic [15:0] FEEDBACK_TARGET_RESET = 16'd32768;
  localparam logic [15:0] DAMP_RESET            = 16'd20000;
  localparam logic [15:0] TIME_SMOOTH_RESET     = 16'd14;
  localparam logic [15:0] GAIN_SMOOTH_RESET     = 16'd66;
  localparam logic [15:0] SEED_GAIN_RESET       = 16'd5120;
endpackage

### hw/rtl/psd_stream_if.sv
// Valid/ready stream interface carrying a payload of parameterized width.
// Depends on nothing.
interface psd_stream_if #(parameter int unsigned W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/psd_cfg_if.sv
// Configuration write interface: register index and write data.
// Depends on psd_pkg.
interface psd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psd_pkg::CfgIdxBits-1:0]    index;
  logic [psd_pkg::CfgDataBits-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pingpong_stereo_delay.sv
// Ping-pong stereo delay top level: sequencer, shared multiplier and both line memories.
// Depends on psd_pkg, psd_stream_if and psd_cfg_if.
// When enabled, each accepted input beat runs through a sequence of steps on the single
// shared 42x26 multiplier before its output beat; when disabled, the output beat is
// registered directly. A new input beat is taken only in idle; a waiting output beat stalls the input.
// Reset clears control state; a clear pass over all LINE_DEPTH entries then blocks input beats.
module pingpong_stereo_delay #(
  parameter int unsigned LINE_DEPTH  = psd_pkg::LineDepthDefault,
  parameter int unsigned SAMPLE_BITS = psd_pkg::SampleBitsDefault
) (
  input logic clk,
  input logic rst_n,
  psd_stream_if.sink   in_s,
  psd_stream_if.source out_s,
  psd_cfg_if.sink      cfg_s
);
  import psd_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned SB = SAMPLE_BITS;
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);
  localparam longint unsigned HIW = (longint'(LINE_DEPTH) - 2) * 256;
  localparam logic [23:0] DHI = (HIW > 64'hFFFFFF) ? 24'hFFFFFF : 24'(HIW);
  localparam logic signed [SB:0] SMAX = (SB+1)'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [SB:0] SMIN = -SMAX - (SB+1)'(1);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_SD = 5'd2, S_SF = 5'd3,
    S_RD0 = 5'd4, S_RD1 = 5'd5, S_RD2 = 5'd6, S_IL = 5'd7, S_IR = 5'd8, S_DL = 5'd9,
    S_DR = 5'd10, S_PAIR = 5'd11, S_GATE = 5'd12, S_WL = 5'd13, S_WR = 5'd14,
    S_OUT = 5'd15;

  logic [4:0] st_r;
  logic [AW-1:0] clr_r, wp_r;
  logic enable_r;
  logic [23:0] dtgt_r;
  logic [15:0] fbt_r, damp_r, tsc_r, gsc_r, sgg_r;
  logic [39:0] sdel_r;
  logic [31:0] sfb_r;
  logic signed [SB-1:0] dl_r, dr_r, tl_r, tr_r, dry_r, l0_r, r0_r, wl_r, wr_r;
  logic [16:0] pair_r, gate_r;
  logic out_v_r;
  logic [2*SB-1:0] out_d_r;

  logic [SB-1:0] lmem [LINE_DEPTH];
  logic [SB-1:0] rmem [LINE_DEPTH];
  logic [AW-1:0] raddr;
  logic [SB-1:0] lq_r, rq_r;
  logic we;
  logic [AW-1:0] waddr;

  // Shared multiplier: signed 42 x signed 26 operands, registered product.
  logic signed [41:0] ma;
  logic signed [25:0] mb;
  logic signed [67:0] mp_r;

  logic [23:0] dcl;
  logic [15:0] ipart;
  logic [23:0] frac;
  logic [AW-1:0] back, i0;
  logic [24:0] fr;
  logic signed [SB+1:0] lsum;

  assign dcl = (dtgt_r < 24'd256) ? 24'd256 : ((dtgt_r > DHI) ? DHI : dtgt_r);
  assign ipart = sdel_r[39:24];
  assign frac = sdel_r[23:0];
  assign back = AW'({16'd0, ipart} + 32'(frac != 24'd0));
  assign fr = (frac != 24'd0) ? (25'h1000000 - {1'b0, frac}) : 25'd0;
  assign i0 = (wp_r >= back) ? (wp_r - back) :
              AW'({1'b0, wp_r} + (AW+1)'(LINE_DEPTH) - {1'b0, back});

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_SD:   begin ma = 42'({dcl, 16'd0}) - 42'(sdel_r); mb = 26'(tsc_r); end
      S_SF:   begin ma = 42'({fbt_r, 16'd0}) - 42'(sfb_r); mb = 26'(gsc_r); end
      S_IL:   begin ma = 42'($signed(lq_r)) - 42'(l0_r); mb = 26'(fr); end
      S_IR:   begin ma = 42'($signed(rq_r)) - 42'(r0_r); mb = 26'(fr); end
      S_DL:   begin ma = 42'(tl_r) - 42'(dl_r); mb = 26'(damp_r); end
      S_DR:   begin ma = 42'(tr_r) - 42'(dr_r); mb = 26'(damp_r); end
      S_PAIR: begin ma = 42'(sfb_r[31:16]); mb = 26'(sfb_r[31:16]); end
      S_GATE: begin ma = 42'(sfb_r[31:16]); mb = 26'(sgg_r); end
      S_WL:   begin ma = 42'(dr_r); mb = 26'(pair_r); end
      S_WR:   begin ma = 42'(dl_r); mb = 26'(gate_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Each step issues a product in its state's first sub-phase and consumes it in the second.
  logic ph_r;

  assign lsum = (SB+2)'(mp_r >>> 16) + (SB+2)'(dry_r);

  function automatic logic signed [SB-1:0] sat(input logic signed [67:0] v);
    if (v > 68'(SMAX)) sat = SMAX[SB-1:0];
    else if (v < 68'(SMIN)) sat = SMIN[SB-1:0];
    else sat = v[SB-1:0];
  endfunction

  assign in_s.ready  = (st_r == S_IDLE) && !out_v_r;
  assign cfg_s.ready = 1'b1;
  assign out_s.valid = out_v_r;
  assign out_s.data  = out_d_r;

  assign raddr = (st_r == S_RD0) ? i0 : ((i0 == LAST) ? '0 : i0 + AW'(1));
  assign we = (st_r == S_CLR) || (st_r == S_OUT);
  assign waddr = (st_r == S_CLR) ? clr_r : wp_r;

  always_ff @(posedge clk) begin
    lq_r <= lmem[raddr];
    rq_r <= rmem[raddr];
    if (we) begin
      lmem[waddr] <= (st_r == S_CLR) ? '0 : wl_r;
      rmem[waddr] <= (st_r == S_CLR) ? '0 : wr_r;
    end
    mp_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      wp_r <= '0;
      ph_r <= 1'b0;
      out_v_r <= 1'b0;
      enable_r <= 1'b0;
      dtgt_r <= DELAY_TARGET_RESET;
      fbt_r <= FEEDBACK_TARGET_RESET;
      damp_r <= DAMP_RESET;
      tsc_r <= TIME_SMOOTH_RESET;
      gsc_r <= GAIN_SMOOTH_RESET;
      sgg_r <= SEED_GAIN_RESET;
      sdel_r <= 40'({(DELAY_TARGET_RESET < 24'd256) ? 24'd256 :
                ((DELAY_TARGET_RESET > DHI) ? DHI : DELAY_TARGET_RESET), 16'd0});
      sfb_r <= {FEEDBACK_TARGET_RESET, 16'd0};
      dl_r <= '0;
      dr_r <= '0;
    end else begin
      if (cfg_s.valid) begin
        case (cfg_s.index)
          REG_ENABLE:      enable_r <= cfg_s.data[0];
          REG_DELAY:       dtgt_r <= cfg_s.data[23:0];
          REG_FEEDBACK:    fbt_r <= cfg_s.data[15:0];
          REG_DAMP:        damp_r <= cfg_s.data[15:0];
          REG_TIME_SMOOTH: tsc_r <= cfg_s.data[15:0];
          REG_GAIN_SMOOTH: gsc_r <= cfg_s.data[15:0];
          REG_SEED_GAIN:   sgg_r <= cfg_s.data[15:0];
          default: ;
        endcase
      end
      if (out_v_r && out_s.ready) out_v_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_s.valid && in_s.ready) begin
            dry_r <= in_s.data[SB-1:0];
            ph_r <= 1'b0;
            if (enable_r) st_r <= S_SD;
            else begin
              out_v_r <= 1'b1;
              out_d_r <= '0;
            end
          end
        end
        S_RD0: st_r <= S_RD1;
        S_RD1: begin
          l0_r <= lq_r;
          r0_r <= rq_r;
          st_r <= S_RD2;
        end
        S_RD2: st_r <= S_IL;
        S_OUT: begin
          wp_r <= (wp_r == LAST) ? '0 : wp_r + AW'(1);
          out_v_r <= 1'b1;
          out_d_r <= {tr_r, tl_r};
          st_r <= S_IDLE;
        end
        default: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            st_r <= st_r + 5'd1;
            case (st_r)
              S_SD:   sdel_r <= sdel_r + 40'(mp_r >>> 16);
              S_SF:   sfb_r <= sfb_r + 32'(mp_r >>> 16);
              S_IL:   tl_r <= l0_r + SB'(mp_r >>> 24);
              S_IR:   tr_r <= r0_r + SB'(mp_r >>> 24);
              S_DL:   dl_r <= dl_r + SB'(mp_r >>> 16);
              S_DR:   dr_r <= dr_r + SB'(mp_r >>> 16);
              S_PAIR: pair_r <= 17'(mp_r >>> 16);
              S_GATE: gate_r <= ((mp_r >>> 8) > 68'sd65536) ? 17'd65536 : 17'(mp_r >>> 8);
              S_WL:   wl_r <= sat(68'(lsum));
              S_WR:   wr_r <= sat(mp_r >>> 16);
              default: ;
            endcase
          end
        end
      endcase
      // Read sequencing: S_SF done goes to S_RD0 directly.
    end
  end

  property p_no_accept_in_clear;
    @(posedge clk) disable iff (!rst_n) (st_r == S_CLR) |-> !in_s.ready;
  endproperty
  a_clear: assert property (p_no_accept_in_clear) else $error("accept during clear");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n) (out_v_r && !out_s.ready) |=> $stable(out_d_r);
  endproperty
  a_hold: assert property (p_out_hold) else $error("output changed while stalled");

  property p_wp_step;
    @(posedge clk) disable iff (!rst_n) (st_r != S_OUT) |=> $stable(wp_r);
  endproperty
  a_wp: assert property (p_wp_step) else $error("write position moved outside write");
endmodule
